FILE: rtl/core/vfq_pkg.sv
package vfq_pkg;

    // Atlas layout and queue sizing.
    localparam int ATLAS_COLUMNS = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Request codes.
    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Face codes.
    localparam logic [2:0] FACE_LEFT   = 3'd0;
    localparam logic [2:0] FACE_RIGHT  = 3'd1;
    localparam logic [2:0] FACE_TOP    = 3'd2;
    localparam logic [2:0] FACE_BOTTOM = 3'd3;
    localparam logic [2:0] FACE_FRONT  = 3'd4;
    localparam logic [2:0] FACE_BACK   = 3'd5;

    // Shade limits.
    localparam logic [8:0] SHADE_FLOOR_BOX    = 9'd32;
    localparam logic [7:0] SHADE_FLOOR_SPRITE = 8'd16;
    localparam logic [7:0] SHADE_FULL         = 8'd255;
    localparam logic [7:0] SPRITE_DARK_LIMIT  = 8'd239;

    // Full cell extent in sixteenths.
    localparam logic [4:0] CELL_EXTENT = 5'd16;

    typedef logic [255:0][7:0] tile_table_t;
    typedef logic [3:0][2:0]   corner_set_t;

    // One classified face, ready for vertex generation.
    typedef struct packed {
        logic              buffer;
        logic [15:0]       base_index;
        logic [4:0]        mn_x;
        logic [4:0]        mn_y;
        logic [4:0]        mn_z;
        logic [4:0]        mx_x;
        logic [4:0]        mx_y;
        logic [4:0]        mx_z;
        logic [3:0]        p_x;
        logic [3:0]        p_y;
        logic [3:0]        p_z;
        corner_set_t       corners;
        logic [7:0]        shade;
        logic [8:0]        umin;
        logic [8:0]        umax;
        logic [8:0]        vmin;
        logic [8:0]        vmax;
    } quad_desc_t;

    // Queue fill status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // Tile row and column tables, built at elaboration.
    function automatic tile_table_t make_tile_row();
        tile_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i / ATLAS_COLUMNS);
        end
        return t;
    endfunction

    function automatic tile_table_t make_tile_col();
        tile_table_t t;
        for (int i = 0; i < 256; i++)
        begin
            t[i] = 8'(i % ATLAS_COLUMNS);
        end
        return t;
    endfunction

    localparam tile_table_t TILE_ROW = make_tile_row();
    localparam tile_table_t TILE_COL = make_tile_col();

    function automatic corner_set_t pack_corners(input logic [2:0] c0, input logic [2:0] c1,
                                                 input logic [2:0] c2, input logic [2:0] c3);
        corner_set_t r;
        r[0] = c0;
        r[1] = c1;
        r[2] = c2;
        r[3] = c3;
        return r;
    endfunction

    // Corner selectors: bit 0 takes x from max, bit 1 y, bit 2 z.
    function automatic corner_set_t box_corners(input logic [2:0] bface);
        corner_set_t r;
        case (bface)
            FACE_LEFT:   r = pack_corners(3'd0, 3'd6, 3'd2, 3'd4);
            FACE_RIGHT:  r = pack_corners(3'd5, 3'd3, 3'd7, 3'd1);
            FACE_TOP:    r = pack_corners(3'd6, 3'd3, 3'd2, 3'd7);
            FACE_BOTTOM: r = pack_corners(3'd0, 3'd5, 3'd4, 3'd1);
            FACE_FRONT:  r = pack_corners(3'd4, 3'd7, 3'd6, 3'd5);
            FACE_BACK:   r = pack_corners(3'd1, 3'd2, 3'd3, 3'd0);
            default:     r = pack_corners(3'd6, 3'd3, 3'd2, 3'd7);
        endcase
        return r;
    endfunction

    function automatic corner_set_t sprite_corners(input logic [1:0] sface);
        corner_set_t r;
        case (sface)
            2'd0:    r = pack_corners(3'd0, 3'd7, 3'd2, 3'd5);
            2'd1:    r = pack_corners(3'd5, 3'd2, 3'd7, 3'd0);
            2'd2:    r = pack_corners(3'd4, 3'd3, 3'd6, 3'd1);
            default: r = pack_corners(3'd1, 3'd6, 3'd3, 3'd4);
        endcase
        return r;
    endfunction

    // Base brightness of a box face.
    function automatic logic [8:0] face_brightness(input logic [2:0] bface);
        logic [8:0] b;
        case (bface)
            FACE_LEFT, FACE_RIGHT: b = 9'd150;
            FACE_BOTTOM:           b = 9'd100;
            FACE_FRONT, FACE_BACK: b = 9'd200;
            default:               b = 9'd255;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/core/vfq_front.sv
module vfq_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   req_type,
    input  logic [2:0]             face,
    input  logic                   sprite,
    input  logic                   buffer_sel,
    input  logic [3:0]             cell_x,
    input  logic [3:0]             cell_y,
    input  logic [3:0]             cell_z,
    input  logic [14:0]            box_min,
    input  logic [14:0]            box_max,
    input  logic [7:0]             tile_id,
    input  logic [7:0]             light,
    input  vfq_pkg::queue_status_t q_status,
    output logic                   push,
    output vfq_pkg::quad_desc_t    push_desc
);

    logic [15:0] count_reg [2];
    logic [15:0] count_next [2];
    logic        accept;
    logic [2:0]  bface;
    logic [4:0]  mn_x, mn_y, mn_z, mx_x, mx_y, mx_z;
    logic [4:0]  u_lo, u_hi, v_lo, v_hi;
    logic [8:0]  tx, ty;
    logic [8:0]  base_bright;
    logic [7:0]  tile_row, tile_col;

    // A transfer is taken whenever the queue has room for a face.
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (req_type == vfq_pkg::REQ_ADD);

    // Classify the face: geometry box, corners, crop and shade.
    always_comb
    begin
        bface = (face > vfq_pkg::FACE_BACK) ? vfq_pkg::FACE_TOP : face;
        tile_row = vfq_pkg::TILE_ROW[tile_id];
        tile_col = vfq_pkg::TILE_COL[tile_id];
        tx = {tile_col[4:0], 4'b0000};
        ty = {tile_row[4:0], 4'b0000};
        base_bright = vfq_pkg::face_brightness(bface);

        if (sprite)
        begin
            mn_x = '0;
            mn_y = '0;
            mn_z = '0;
            mx_x = vfq_pkg::CELL_EXTENT;
            mx_y = vfq_pkg::CELL_EXTENT;
            mx_z = vfq_pkg::CELL_EXTENT;
        end
        else
        begin
            mn_x = box_min[4:0];
            mn_y = box_min[9:5];
            mn_z = box_min[14:10];
            mx_x = box_max[4:0];
            mx_y = box_max[9:5];
            mx_z = box_max[14:10];
        end

        // Texture crop axes follow the face orientation.
        if (sprite)
        begin
            u_lo = '0;
            u_hi = vfq_pkg::CELL_EXTENT;
            v_lo = '0;
            v_hi = vfq_pkg::CELL_EXTENT;
        end
        else if (bface == vfq_pkg::FACE_FRONT || bface == vfq_pkg::FACE_BACK)
        begin
            u_lo = mn_x;
            u_hi = mx_x;
            v_lo = mn_y;
            v_hi = mx_y;
        end
        else if (bface == vfq_pkg::FACE_LEFT || bface == vfq_pkg::FACE_RIGHT)
        begin
            u_lo = mn_z;
            u_hi = mx_z;
            v_lo = mn_y;
            v_hi = mx_y;
        end
        else
        begin
            u_lo = mn_x;
            u_hi = mx_x;
            v_lo = mn_z;
            v_hi = mx_z;
        end

        push_desc.buffer     = buffer_sel;
        push_desc.base_index = count_reg[buffer_sel];
        push_desc.mn_x       = mn_x;
        push_desc.mn_y       = mn_y;
        push_desc.mn_z       = mn_z;
        push_desc.mx_x       = mx_x;
        push_desc.mx_y       = mx_y;
        push_desc.mx_z       = mx_z;
        push_desc.p_x        = cell_x;
        push_desc.p_y        = cell_y;
        push_desc.p_z        = cell_z;
        push_desc.corners    = sprite ? vfq_pkg::sprite_corners(face[1:0])
                                      : vfq_pkg::box_corners(bface);
        push_desc.umin       = tx + 9'(u_lo);
        push_desc.umax       = tx + 9'(u_hi);
        push_desc.vmin       = ty + 9'(v_lo);
        push_desc.vmax       = ty + 9'(v_hi);

        if (sprite)
        begin
            push_desc.shade = (light > vfq_pkg::SPRITE_DARK_LIMIT)
                            ? vfq_pkg::SHADE_FLOOR_SPRITE : (vfq_pkg::SHADE_FULL - light);
        end
        else if ((9'(light) + vfq_pkg::SHADE_FLOOR_BOX) > base_bright)
        begin
            push_desc.shade = vfq_pkg::SHADE_FLOOR_BOX[7:0];
        end
        else
        begin
            push_desc.shade = 8'(base_bright - 9'(light));
        end
    end

    // Per-buffer vertex counters advance by four at acceptance of an add, so order is kept; a clear zeroes both.
    always_comb
    begin
        count_next[0] = count_reg[0];
        count_next[1] = count_reg[1];
        if (accept)
        begin
            if (req_type == vfq_pkg::REQ_CLEAR)
            begin
                count_next[0] = '0;
                count_next[1] = '0;
            end
            else
            begin
                count_next[buffer_sel] = count_reg[buffer_sel] + 16'd4;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg[0] <= '0;
            count_reg[1] <= '0;
        end
        else
        begin
            count_reg[0] <= count_next[0];
            count_reg[1] <= count_next[1];
        end
    end

endmodule

FILE: rtl/core/vfq_queue.sv
module vfq_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  vfq_pkg::quad_desc_t    push_desc,
    input  logic                   pop,
    output vfq_pkg::quad_desc_t    head_desc,
    output vfq_pkg::queue_status_t status
);

    localparam int CW = $clog2(vfq_pkg::QUEUE_DEPTH + 1);

    vfq_pkg::quad_desc_t          mem_reg [vfq_pkg::QUEUE_DEPTH];
    logic [vfq_pkg::QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [vfq_pkg::QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]                count_reg, count_next;

    assign status.full  = (count_reg == CW'(vfq_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_desc    = mem_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == vfq_pkg::QUEUE_AW'(vfq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == vfq_pkg::QUEUE_AW'(vfq_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

FILE: rtl/core/vfq_back.sv
module vfq_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  vfq_pkg::quad_desc_t    head_desc,
    input  vfq_pkg::queue_status_t q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   out_buffer,
    output logic [15:0]            vertex_index,
    output logic [7:0]             vert_x,
    output logic [7:0]             vert_y,
    output logic [7:0]             vert_z,
    output logic [7:0]             shade,
    output logic [8:0]             tex_u,
    output logic [8:0]             tex_v,
    output logic                   last
);

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  corner_reg, corner_next;
    logic        load;
    logic [2:0]  sel;
    logic        out_buffer_reg;
    logic [15:0] vertex_index_reg;
    logic [7:0]  vert_x_reg, vert_y_reg, vert_z_reg, shade_reg;
    logic [8:0]  tex_u_reg, tex_v_reg;
    logic        last_reg;

    // Byte coordinate: floor(15 * (c + 16 * p) / 16), low eight bits.
    function automatic logic [7:0] quant(input logic [4:0] c, input logic [3:0] p);
        logic [8:0]  sum;
        logic [12:0] prod;
        sum  = {1'b0, p, 4'b0000} + 9'(c);
        prod = {sum, 4'b0000} - 13'(sum);
        return prod[11:4];
    endfunction

    // The output register is refilled when empty or when its vertex leaves.
    assign load = !out_valid_reg || out_ready;
    assign pop  = load && !q_status.empty && (corner_reg == 2'd3);
    assign sel  = head_desc.corners[corner_reg];

    always_comb
    begin
        out_valid_next = out_valid_reg;
        corner_next    = corner_reg;
        if (load)
        begin
            out_valid_next = !q_status.empty;
            if (!q_status.empty)
            begin
                corner_next = corner_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            corner_reg    <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            corner_reg    <= corner_next;
        end
    end

    // Vertex payload for the current corner of the head face.
    always_ff @(posedge clk)
    begin
        if (load && !q_status.empty)
        begin
            out_buffer_reg   <= head_desc.buffer;
            vertex_index_reg <= head_desc.base_index + 16'(corner_reg);
            vert_x_reg <= quant(sel[0] ? head_desc.mx_x : head_desc.mn_x, head_desc.p_x);
            vert_y_reg <= quant(sel[1] ? head_desc.mx_y : head_desc.mn_y, head_desc.p_y);
            vert_z_reg <= quant(sel[2] ? head_desc.mx_z : head_desc.mn_z, head_desc.p_z);
            shade_reg  <= head_desc.shade;
            tex_u_reg  <= (corner_reg == 2'd0 || corner_reg == 2'd2)
                        ? head_desc.umin : head_desc.umax;
            tex_v_reg  <= (corner_reg == 2'd1 || corner_reg == 2'd2)
                        ? head_desc.vmin : head_desc.vmax;
            last_reg   <= (corner_reg == 2'd3);
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_buffer   = out_buffer_reg;
    assign vertex_index = vertex_index_reg;
    assign vert_x       = vert_x_reg;
    assign vert_y       = vert_y_reg;
    assign vert_z       = vert_z_reg;
    assign shade        = shade_reg;
    assign tex_u        = tex_u_reg;
    assign tex_v        = tex_v_reg;
    assign last         = last_reg;

endmodule

FILE: rtl/core/voxel_face_quad_emitter.sv
// Voxel face quad emitter. Each add-face transfer yields four vertex transfers on the
// output channel, one per clock while out_ready is high, so a steady stream of faces is
// limited by the single vertex output port. A clear transfer resets both vertex counters
// and yields no vertices. Faces are classified on entry and wait in a two-entry queue,
// so the input keeps accepting while the output stalls until the queue is full; an
// accepted face is written into the queue, then loaded into the output register.

module voxel_face_quad_emitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [2:0]  face,
    input  logic        sprite,
    input  logic        buffer_sel,
    input  logic [3:0]  cell_x,
    input  logic [3:0]  cell_y,
    input  logic [3:0]  cell_z,
    input  logic [14:0] box_min,
    input  logic [14:0] box_max,
    input  logic [7:0]  tile_id,
    input  logic [7:0]  light,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_buffer,
    output logic [15:0] vertex_index,
    output logic [7:0]  vert_x,
    output logic [7:0]  vert_y,
    output logic [7:0]  vert_z,
    output logic [7:0]  shade,
    output logic [8:0]  tex_u,
    output logic [8:0]  tex_v,
    output logic        last
);

    vfq_pkg::queue_status_t q_status;
    vfq_pkg::quad_desc_t    push_desc;
    vfq_pkg::quad_desc_t    head_desc;
    logic                   push;
    logic                   pop;

    // Front: accept, classify and count vertices.
    vfq_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .face       (face),
        .sprite     (sprite),
        .buffer_sel (buffer_sel),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .cell_z     (cell_z),
        .box_min    (box_min),
        .box_max    (box_max),
        .tile_id    (tile_id),
        .light      (light),
        .q_status   (q_status),
        .push       (push),
        .push_desc  (push_desc)
    );

    // Decoupling queue of classified faces.
    vfq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (q_status)
    );

    // Back: emit four vertices per face.
    vfq_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_desc    (head_desc),
        .q_status     (q_status),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_buffer   (out_buffer),
        .vertex_index (vertex_index),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .shade        (shade),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .last         (last)
    );

    // A quad never stalls internally once its first vertex is out.
    a_quad_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid)
        else $error("vertex stream broke inside a quad");

    // Vertices of one quad are numbered consecutively in the same buffer.
    a_quad_index_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=>
            (vertex_index == $past(vertex_index) + 16'd1) && (out_buffer == $past(out_buffer)))
        else $error("vertex index not consecutive within a quad");

    // The queue never takes a face while full or gives one while empty.
    a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_status.full) && !(pop && q_status.empty))
        else $error("queue overflow or underflow");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

    // Run length limits.
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_FACES  = 380;
    localparam int TAIL_FACES    = 50;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    // Base brightness of the box faces.
    localparam int BRIGHT_SIDE   = 150;
    localparam int BRIGHT_TOP    = 255;
    localparam int BRIGHT_BOTTOM = 100;
    localparam int BRIGHT_FRONT  = 200;

    // Corner selectors per face: bit 0 takes x from the max corner, bit 1 y, bit 2 z.
    localparam bit [2:0] BOX_PICK [6][4] = '{
        '{3'd0, 3'd6, 3'd2, 3'd4}, '{3'd5, 3'd3, 3'd7, 3'd1}, '{3'd6, 3'd3, 3'd2, 3'd7},
        '{3'd0, 3'd5, 3'd4, 3'd1}, '{3'd4, 3'd7, 3'd6, 3'd5}, '{3'd1, 3'd2, 3'd3, 3'd0}
    };
    localparam bit [2:0] SPRITE_PICK [4][4] = '{
        '{3'd0, 3'd7, 3'd2, 3'd5}, '{3'd5, 3'd2, 3'd7, 3'd0},
        '{3'd4, 3'd3, 3'd6, 3'd1}, '{3'd1, 3'd6, 3'd3, 3'd4}
    };

    // One input transfer, in port order.
    typedef struct packed {
        logic        req;
        logic [2:0]  face;
        logic        sprite;
        logic        buffer;
        logic [3:0]  cx;
        logic [3:0]  cy;
        logic [3:0]  cz;
        logic [14:0] box_lo;
        logic [14:0] box_hi;
        logic [7:0]  tile;
        logic [7:0]  light;
    } face_req_t;

    // One vertex transfer, in port order.
    typedef struct packed {
        logic        buffer;
        logic [15:0] index;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  z;
        logic [7:0]  tone;
        logic [8:0]  u;
        logic [8:0]  v;
        logic        last;
    } vertex_t;

    // Tracks the vertex counters and the vertices each face must produce.
    class quad_tracker;
        bit [15:0] vertex_count [2];
        vertex_t   due_vertices [$];
        int        errors;

        function logic [7:0] to_byte(logic [4:0] c, logic [3:0] p);
            int t;
            t = 15 * (int'(c) + 16 * int'(p));
            return 8'(t >> 4);
        endfunction

        function string show(vertex_t v);
            return $sformatf("buf=%0d idx=%0d pos=(%0d,%0d,%0d) shade=%0d uv=(%0d,%0d) last=%0d",
                             v.buffer, v.index, v.x, v.y, v.z, v.tone, v.u, v.v, v.last);
        endfunction

        // Work out the four vertices of an accepted face, or clear the counters.
        function void note_face(face_req_t r);
            logic [4:0] lo [3];
            logic [4:0] hi [3];
            logic [3:0] pos [3];
            bit   [2:0] pick [4];
            logic [2:0] kind;
            logic [8:0] tx, ty, u_lo, u_hi, v_lo, v_hi;
            logic [7:0] tone;
            int         bright;
            vertex_t    vx;
            if (r.req == vfq_pkg::REQ_CLEAR)
            begin
                vertex_count[0] = '0;
                vertex_count[1] = '0;
                return;
            end
            for (int a = 0; a < 3; a++)
            begin
                lo[a] = r.box_lo[5 * a +: 5];
                hi[a] = r.box_hi[5 * a +: 5];
            end
            pos[0] = r.cx;
            pos[1] = r.cy;
            pos[2] = r.cz;
            tx = 9'((int'(r.tile) % vfq_pkg::ATLAS_COLUMNS) * 16);
            ty = 9'((int'(r.tile) / vfq_pkg::ATLAS_COLUMNS) * 16);
            u_lo = tx;
            u_hi = tx + 9'd16;
            v_lo = ty;
            v_hi = ty + 9'd16;
            if (r.sprite)
            begin
                // Crossed sprite: full cell, face wraps into the four diagonals.
                pick = SPRITE_PICK[r.face[1:0]];
                for (int a = 0; a < 3; a++)
                begin
                    lo[a] = '0;
                    hi[a] = vfq_pkg::CELL_EXTENT;
                end
                tone = (r.light > vfq_pkg::SPRITE_DARK_LIMIT) ? vfq_pkg::SHADE_FLOOR_SPRITE
                                                               : vfq_pkg::SHADE_FULL - r.light;
            end
            else
            begin
                // Box model: faces beyond back behave as top; texture cropped to the box.
                kind = (r.face > vfq_pkg::FACE_BACK) ? vfq_pkg::FACE_TOP : r.face;
                pick = BOX_PICK[kind];
                case (kind)
                    vfq_pkg::FACE_FRONT, vfq_pkg::FACE_BACK:
                    begin
                        u_lo = tx + 9'(lo[0]);
                        u_hi = tx + 9'(hi[0]);
                        v_lo = ty + 9'(lo[1]);
                        v_hi = ty + 9'(hi[1]);
                        bright = BRIGHT_FRONT;
                    end
                    vfq_pkg::FACE_LEFT, vfq_pkg::FACE_RIGHT:
                    begin
                        u_lo = tx + 9'(lo[2]);
                        u_hi = tx + 9'(hi[2]);
                        v_lo = ty + 9'(lo[1]);
                        v_hi = ty + 9'(hi[1]);
                        bright = BRIGHT_SIDE;
                    end
                    default:
                    begin
                        u_lo = tx + 9'(lo[0]);
                        u_hi = tx + 9'(hi[0]);
                        v_lo = ty + 9'(lo[2]);
                        v_hi = ty + 9'(hi[2]);
                        bright = (kind == vfq_pkg::FACE_BOTTOM) ? BRIGHT_BOTTOM : BRIGHT_TOP;
                    end
                endcase
                if (int'(r.light) + int'(vfq_pkg::SHADE_FLOOR_BOX) > bright)
                    tone = 8'(vfq_pkg::SHADE_FLOOR_BOX);
                else
                    tone = 8'(bright - int'(r.light));
            end
            for (int i = 0; i < 4; i++)
            begin
                vx.buffer = r.buffer;
                vx.index  = vertex_count[r.buffer] + 16'(i);
                vx.x      = to_byte(pick[i][0] ? hi[0] : lo[0], pos[0]);
                vx.y      = to_byte(pick[i][1] ? hi[1] : lo[1], pos[1]);
                vx.z      = to_byte(pick[i][2] ? hi[2] : lo[2], pos[2]);
                vx.tone   = tone;
                vx.u      = (i == 0 || i == 2) ? u_lo : u_hi;
                vx.v      = (i == 1 || i == 2) ? v_lo : v_hi;
                vx.last   = (i == 3);
                due_vertices.push_back(vx);
            end
            vertex_count[r.buffer] = vertex_count[r.buffer] + 16'd4;
        endfunction

        // Compare an output transfer with the oldest pending vertex.
        function void check_vertex(vertex_t got);
            vertex_t want;
            if (due_vertices.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected vertex: %s", show(got));
                return;
            end
            want = due_vertices.pop_front();
            if (got.buffer !== want.buffer || got.index !== want.index || got.x !== want.x ||
                got.y !== want.y || got.z !== want.z || got.tone !== want.tone ||
                got.u !== want.u || got.v !== want.v || got.last !== want.last)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("vertex mismatch at %0t", $time);
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = 1'b0;
    logic [2:0]  face = '0;
    logic        sprite = 1'b0;
    logic        buffer_sel = 1'b0;
    logic [3:0]  cell_x = '0;
    logic [3:0]  cell_y = '0;
    logic [3:0]  cell_z = '0;
    logic [14:0] box_min = '0;
    logic [14:0] box_max = '0;
    logic [7:0]  tile_id = '0;
    logic [7:0]  light = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_buffer;
    logic [15:0] vertex_index;
    logic [7:0]  vert_x;
    logic [7:0]  vert_y;
    logic [7:0]  vert_z;
    logic [7:0]  shade;
    logic [8:0]  tex_u;
    logic [8:0]  tex_v;
    logic        last;

    logic        hold_go = 1'b0;
    logic        calm = 1'b0;
    bit          hold_done;
    int          cycles;
    face_req_t   directed [$];
    quad_tracker qt = new();

    voxel_face_quad_emitter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .face         (face),
        .sprite       (sprite),
        .buffer_sel   (buffer_sel),
        .cell_x       (cell_x),
        .cell_y       (cell_y),
        .cell_z       (cell_z),
        .box_min      (box_min),
        .box_max      (box_max),
        .tile_id      (tile_id),
        .light        (light),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_buffer   (out_buffer),
        .vertex_index (vertex_index),
        .vert_x       (vert_x),
        .vert_y       (vert_y),
        .vert_z       (vert_z),
        .shade        (shade),
        .tex_u        (tex_u),
        .tex_v        (tex_v),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Input transfers feed the tracker.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            qt.note_face({req_type, face, sprite, buffer_sel, cell_x, cell_y, cell_z,
                          box_min, box_max, tile_id, light});
    end

    // Output transfers are checked against the tracker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            qt.check_vertex({out_buffer, vertex_index, vert_x, vert_y, vert_z, shade,
                             tex_u, tex_v, last});
    end

    // Receiver: random stall bursts, one long hold-off on request, none once calm.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    function automatic logic [14:0] pack_box(int x, int y, int z);
        return {5'(z), 5'(y), 5'(x)};
    endfunction

    function automatic face_req_t make_face(logic [2:0] f, logic spr, logic sel, int px, int py,
                                            int pz, logic [14:0] lo, logic [14:0] hi,
                                            int tile, int lt);
        face_req_t r;
        r.req    = vfq_pkg::REQ_ADD;
        r.face   = f;
        r.sprite = spr;
        r.buffer = sel;
        r.cx     = 4'(px);
        r.cy     = 4'(py);
        r.cz     = 4'(pz);
        r.box_lo = lo;
        r.box_hi = hi;
        r.tile   = 8'(tile);
        r.light  = 8'(lt);
        return r;
    endfunction

    // Mostly well-formed boxes within the cell; some raw boxes and a few clears.
    function automatic face_req_t rand_face();
        face_req_t r;
        int        lo_c;
        int        hi_c;
        r = face_req_t'({$urandom, $urandom});
        r.req = ($urandom_range(0, 39) == 0) ? vfq_pkg::REQ_CLEAR : vfq_pkg::REQ_ADD;
        r.sprite = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0)
            r.light = 8'($urandom_range(60, 250));
        if ($urandom_range(0, 7) != 0)
        begin
            for (int a = 0; a < 3; a++)
            begin
                lo_c = $urandom_range(0, 16);
                hi_c = $urandom_range(lo_c, 16);
                r.box_lo[5 * a +: 5] = 5'(lo_c);
                r.box_hi[5 * a +: 5] = 5'(hi_c);
            end
        end
        return r;
    endfunction

    // Offer one item and hold it until the transfer.
    task automatic send_face(input face_req_t r);
        in_valid <= 1'b1;
        {req_type, face, sprite, buffer_sel, cell_x, cell_y, cell_z, box_min, box_max,
         tile_id, light} <= r;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_gap(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (qt.due_vertices.size() != 0);
    endtask

    initial
    begin
        face_req_t   clr;
        face_req_t   r;
        logic [14:0] full_lo;
        logic [14:0] full_hi;
        full_lo = pack_box(0, 0, 0);
        full_hi = pack_box(16, 16, 16);
        clr = '0;
        clr.req = vfq_pkg::REQ_CLEAR;

        // Every face number on the box model, including the two beyond back.
        directed.push_back(make_face(vfq_pkg::FACE_LEFT, 0, 0, 0, 0, 0, full_lo, full_hi,
                                     0, 0));
        directed.push_back(make_face(vfq_pkg::FACE_RIGHT, 0, 1, 15, 15, 15, full_lo, full_hi,
                                     15, 0));
        directed.push_back(make_face(vfq_pkg::FACE_TOP, 0, 0, 3, 7, 9, pack_box(2, 4, 6),
                                     pack_box(12, 10, 14), 16, 0));
        directed.push_back(make_face(vfq_pkg::FACE_BOTTOM, 0, 1, 8, 1, 4, pack_box(1, 0, 3),
                                     pack_box(15, 8, 13), 255, 0));
        directed.push_back(make_face(vfq_pkg::FACE_FRONT, 0, 0, 5, 9, 2, pack_box(3, 5, 7),
                                     pack_box(9, 11, 16), 37, 0));
        directed.push_back(make_face(vfq_pkg::FACE_BACK, 0, 1, 12, 6, 10, pack_box(0, 2, 4),
                                     pack_box(16, 14, 12), 200, 0));
        directed.push_back(make_face(3'd6, 0, 0, 1, 2, 3, pack_box(4, 4, 4),
                                     pack_box(12, 12, 12), 77, 10));
        directed.push_back(make_face(3'd7, 0, 1, 14, 13, 11, full_lo, full_hi, 128, 20));
        // Shade right at and around the box floor.
        directed.push_back(make_face(vfq_pkg::FACE_LEFT, 0, 0, 2, 2, 2, full_lo, full_hi,
                                     5, 117));
        directed.push_back(make_face(vfq_pkg::FACE_RIGHT, 0, 0, 2, 2, 2, full_lo, full_hi,
                                     5, 118));
        directed.push_back(make_face(vfq_pkg::FACE_BOTTOM, 0, 0, 4, 4, 4, full_lo, full_hi,
                                     6, 67));
        directed.push_back(make_face(vfq_pkg::FACE_TOP, 0, 1, 4, 4, 4, full_lo, full_hi,
                                     6, 255));
        // Sprites: shade around its floor, face numbers above three wrap.
        directed.push_back(make_face(vfq_pkg::FACE_LEFT, 1, 0, 7, 8, 9, 15'h7fff, 15'h0000,
                                     1, 239));
        directed.push_back(make_face(vfq_pkg::FACE_BOTTOM, 1, 1, 0, 15, 0, full_lo, full_hi,
                                     254, 240));
        directed.push_back(make_face(vfq_pkg::FACE_FRONT, 1, 0, 15, 0, 15, full_lo, full_hi,
                                     99, 0));
        directed.push_back(make_face(3'd7, 1, 1, 6, 6, 6, full_lo, full_hi, 255, 255));
        // Box components beyond the cell, and an inverted box.
        directed.push_back(make_face(vfq_pkg::FACE_FRONT, 0, 0, 15, 15, 15, 15'h0000,
                                     15'h7fff, 255, 1));
        directed.push_back(make_face(vfq_pkg::FACE_RIGHT, 0, 1, 15, 15, 15, 15'h7fff,
                                     15'h0000, 255, 2));
        directed.push_back(make_face(vfq_pkg::FACE_TOP, 0, 0, 0, 0, 0, 15'h7fff, 15'h7fff,
                                     240, 3));
        // Clear, then both counters start again from zero.
        directed.push_back(clr);
        directed.push_back(make_face(vfq_pkg::FACE_BACK, 0, 1, 9, 9, 9, full_lo, full_hi,
                                     50, 40));
        directed.push_back(make_face(vfq_pkg::FACE_LEFT, 0, 0, 9, 9, 9, full_lo, full_hi,
                                     51, 41));
        directed.push_back(make_face(vfq_pkg::FACE_LEFT, 0, 1, 9, 9, 9, full_lo, full_hi,
                                     52, 42));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
            send_face(directed[k]);

        // Random part with idling on both sides and the two pressure phases.
        for (int n = 0; n < RANDOM_FACES; n++)
        begin
            if (n == 150)
                hold_go <= 1'b1;
            if (n == 300)
                wait_drained();
            send_face(rand_face());
            if (!(n >= 150 && n < 175) && $urandom_range(0, 3) == 0)
                idle_gap($urandom_range(1, 8));
        end

        // Calm tail: faces back to back, with no idle gaps on the input and no receiver stalls.
        calm <= 1'b1;
        for (int n = 0; n < TAIL_FACES; n++)
        begin
            r = rand_face();
            r.req = vfq_pkg::REQ_ADD;
            r.buffer = 1'b0;
            send_face(r);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (qt.errors == 0 && qt.due_vertices.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/vfq_pkg.sv
rtl/core/vfq_front.sv
rtl/core/vfq_queue.sv
rtl/core/vfq_back.sv
rtl/core/voxel_face_quad_emitter.sv
sim/tb.sv
